### design/dbia_pkg.sv
// Shared constants, types and a digit helper for the decimal big-integer ALU.
`default_nettype none
package dbia_pkg;

  localparam int DIGITS     = 32;
  localparam int OUT_DIGITS = (DIGITS < 32) ? DIGITS : 32;
  localparam int IDX_W      = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam int J_W        = $clog2(DIGITS + 1);
  localparam int W_IDX      = $clog2(2 * DIGITS);

  localparam logic [1:0] KIND_LOAD_A = 2'd0;
  localparam logic [1:0] KIND_LOAD_B = 2'd1;
  localparam logic [1:0] KIND_EXEC   = 2'd2;
  localparam logic [1:0] KIND_RSVD   = 2'd3;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_CMP = 2'd3;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load_a;
    logic load_b;
    logic init;
    logic scan;
    logic arith;
    logic emit;
  } dbia_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic scan_done;
    logic arith_done;
    logic is_compare;
    logic out_free;
    logic emit_last;
  } dbia_stat_t;

  // Split a value of at most 99 into tens and units
  function automatic logic [7:0] div10(input logic [6:0] t);
    logic [14:0] prod;
    logic [3:0]  q;
    logic [6:0]  r;
    begin
      prod = 15'(t) * 15'd205;
      q    = prod[14:11];
      r    = t - 7'(q) * 7'd10;
      div10 = {q, r[3:0]};
    end
  endfunction

endpackage
`default_nettype wire

### design/dbia_ctrl.sv
// Controller state machine of the decimal big-integer ALU.
`default_nettype none
module dbia_ctrl
  import dbia_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  input  wire logic [1:0] kind,
  output logic            s_tready,
  input  wire dbia_stat_t stat,
  output dbia_cmd_t       cmd
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_ARITH = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  state_t state, state_next;

  assign s_tready = (state == ST_IDLE);

  // Decode requests and sequence the phases
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          unique case (kind)
            KIND_LOAD_A: cmd.load_a = 1'b1;
            KIND_LOAD_B: cmd.load_b = 1'b1;
            KIND_EXEC: begin
              cmd.init   = 1'b1;
              state_next = ST_SCAN;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_done) begin
          state_next = stat.is_compare ? ST_EMIT : ST_ARITH;
        end
      end
      ST_ARITH: begin
        cmd.arith = 1'b1;
        if (stat.arith_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.emit_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

### design/dbia_datapath.sv
// Operand storage, digit arithmetic and result register of the decimal ALU.
`default_nettype none
module dbia_datapath
  import dbia_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire dbia_cmd_t  cmd,
  output dbia_stat_t      stat,
  input  wire logic [4:0] position,
  input  wire logic [3:0] digit_value,
  input  wire logic [1:0] operation,
  input  wire logic       m_tready,
  output logic            m_tvalid,
  output logic [4:0]      digit_position,
  output logic [3:0]      result_digit,
  output logic            negative,
  output logic            overflow,
  output logic            equal,
  output logic            greater,
  output logic            less,
  output logic            a_is_zero,
  output logic            b_is_zero,
  output logic            m_tlast
);

  logic [3:0] a_mem   [DIGITS];
  logic [3:0] b_mem   [DIGITS];
  logic [3:0] work_lo [DIGITS];
  logic [3:0] work_hi [DIGITS];

  logic [J_W-1:0]   j;
  logic [IDX_W-1:0] i;
  logic [3:0]       carry;
  logic [1:0]       op;
  logic             gt, lt, a_nz, b_nz, ovf;

  logic [IDX_W-1:0] jx, sidx, a_addr, b_addr, w_rd, w_wr;
  logic [W_IDX-1:0] sum_ij, w_full;
  logic             rd_hi, wr_hi, j_last, j_end, i_last, is_mul;
  logic [3:0]       a_d, b_d, w_d, dig, big, sml;
  logic [4:0]       need;
  logic [6:0]       t;
  logic [7:0]       qr;
  logic [3:0]       res;
  logic [3:0]       carry_next;
  logic             out_free;

  assign jx     = j[IDX_W-1:0];
  assign sidx   = IDX_W'(DIGITS - 1) - jx;
  assign j_last = (j == J_W'(DIGITS - 1));
  assign j_end  = (j == J_W'(DIGITS));
  assign i_last = (i == IDX_W'(DIGITS - 1));
  assign is_mul = (op == OP_MUL);

  // Pick one read address per array
  assign a_addr = cmd.scan ? sidx : jx;
  assign b_addr = cmd.scan ? sidx : (is_mul ? i : jx);
  assign a_d    = a_mem[a_addr];
  assign b_d    = b_mem[b_addr];

  assign sum_ij = W_IDX'(i) + W_IDX'(jx);
  assign rd_hi  = !cmd.emit && (sum_ij >= W_IDX'(DIGITS));
  assign w_rd   = cmd.emit ? jx
                : (rd_hi ? IDX_W'(sum_ij - W_IDX'(DIGITS)) : IDX_W'(sum_ij));
  assign w_d    = rd_hi ? work_hi[w_rd] : work_lo[w_rd];

  // Write address: row end of multiply drops its carry at i + DIGITS
  assign w_full = (is_mul && j_end) ? (W_IDX'(i) + W_IDX'(DIGITS))
                : (is_mul ? sum_ij : W_IDX'(jx));
  assign wr_hi  = (w_full >= W_IDX'(DIGITS));
  assign w_wr   = wr_hi ? IDX_W'(w_full - W_IDX'(DIGITS)) : IDX_W'(w_full);

  assign dig  = (digit_value > 4'd9) ? 4'd9 : digit_value;
  assign big  = lt ? b_d : a_d;
  assign sml  = lt ? a_d : b_d;
  assign need = 5'(sml) + 5'(carry);

  // One digit step of the selected operation
  always_comb begin
    t = '0;
    unique case (op)
      OP_ADD: t = 7'(a_d) + 7'(b_d) + 7'(carry);
      OP_MUL: t = ((i == '0) ? 7'd0 : 7'(w_d)) + 7'(a_d) * 7'(b_d) + 7'(carry);
      default: t = '0;
    endcase
    qr = div10(t);
    if (op == OP_SUB) begin
      if (5'(big) >= need) begin
        res        = 4'(5'(big) - need);
        carry_next = 4'd0;
      end else begin
        res        = 4'(5'(big) + 5'd10 - need);
        carry_next = 4'd1;
      end
    end else begin
      res        = qr[3:0];
      carry_next = qr[7:4];
    end
  end

  assign out_free        = !m_tvalid || m_tready;
  assign stat.scan_done  = j_last;
  assign stat.arith_done = is_mul ? (j_end && i_last) : j_last;
  assign stat.is_compare = (op == OP_CMP);
  assign stat.out_free   = out_free;
  assign stat.emit_last  = (op == OP_CMP) || (j == J_W'(OUT_DIGITS - 1));

  // Operand loads
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DIGITS; k++) begin
        a_mem[k] <= '0;
        b_mem[k] <= '0;
      end
    end else if (32'(position) < DIGITS) begin
      if (cmd.load_a) a_mem[IDX_W'(position)] <= dig;
      if (cmd.load_b) b_mem[IDX_W'(position)] <= dig;
    end
  end

  // Scratch digits
  always_ff @(posedge clk) begin
    if (cmd.arith) begin
      if (is_mul && j_end) begin
        if (wr_hi) work_hi[w_wr] <= carry;
        else work_lo[w_wr] <= carry;
      end else begin
        if (wr_hi) work_hi[w_wr] <= res;
        else work_lo[w_wr] <= res;
      end
    end
  end

  // Counters, carry and flags
  always_ff @(posedge clk) begin
    if (rst) begin
      j <= '0; i <= '0; carry <= '0; op <= OP_ADD;
      gt <= 1'b0; lt <= 1'b0; a_nz <= 1'b0; b_nz <= 1'b0; ovf <= 1'b0;
    end else if (cmd.init) begin
      j <= '0; i <= '0; carry <= '0; op <= operation;
      gt <= 1'b0; lt <= 1'b0; a_nz <= 1'b0; b_nz <= 1'b0; ovf <= 1'b0;
    end else if (cmd.scan) begin
      if (!gt && !lt) begin
        gt <= (a_d > b_d);
        lt <= (a_d < b_d);
      end
      a_nz <= a_nz | (a_d != 4'd0);
      b_nz <= b_nz | (b_d != 4'd0);
      j    <= j_last ? '0 : j + 1'b1;
    end else if (cmd.arith) begin
      if (is_mul) begin
        if (j_end) begin
          ovf   <= ovf | (carry != 4'd0);
          carry <= '0;
          j     <= '0;
          i     <= i + 1'b1;
        end else begin
          carry <= carry_next;
          j     <= j + 1'b1;
          // Any nonzero digit landing above the kept digits means overflow
          if (wr_hi && res != 4'd0) ovf <= 1'b1;
        end
      end else begin
        carry <= carry_next;
        j     <= j_last ? '0 : j + 1'b1;
        if (op == OP_ADD && j_last) ovf <= (carry_next != 4'd0);
      end
    end else if (cmd.emit) begin
      j <= j + 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      digit_position <= 5'(j);
      result_digit   <= (op == OP_CMP) ? 4'd0 : w_d;
      negative       <= (op == OP_SUB) && lt;
      overflow       <= ovf && (op == OP_ADD || op == OP_MUL);
      equal          <= !gt && !lt;
      greater        <= gt;
      less           <= lt;
      a_is_zero      <= !a_nz;
      b_is_zero      <= !b_nz;
      m_tlast        <= stat.emit_last;
    end
  end

endmodule
`default_nettype wire

### design/decimal_big_integer_alu_core.sv
// Top level of the decimal big-integer ALU: stream ports, controller and datapath.
// An execute scans the operands for compare and zero flags, then add or subtract
// make one pass over the digits and multiply works through a single digit
// multiply-accumulate step, then one result digit per cycle, while the output is not
// stalled by m_tready, leaves through the output register (one for compare).
// A new request is taken once the last result of the previous one is registered.
// Reset (rst, synchronous) clears both operands, the flags and the controller.
`default_nettype none
module decimal_big_integer_alu_core
  import dbia_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,  // position[4:0], digit_value[8:5], operation[10:9]
  input  wire logic [1:0]  s_tuser,  // kind[1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,  // digit_position[4:0], result_digit[8:5]
  output logic [6:0]       m_tuser,  // negative, overflow, equal, greater, less,
                                     // a_is_zero, b_is_zero
  output logic             m_tlast
);

  dbia_cmd_t  cmd;
  dbia_stat_t stat;
  logic [4:0] digit_position;
  logic [3:0] result_digit;
  logic       negative, overflow, equal, greater, less, a_is_zero, b_is_zero;

  dbia_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .kind     (s_tuser),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  dbia_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .position       (s_tdata[4:0]),
    .digit_value    (s_tdata[8:5]),
    .operation      (s_tdata[10:9]),
    .m_tready       (m_tready),
    .m_tvalid       (m_tvalid),
    .digit_position (digit_position),
    .result_digit   (result_digit),
    .negative       (negative),
    .overflow       (overflow),
    .equal          (equal),
    .greater        (greater),
    .less           (less),
    .a_is_zero      (a_is_zero),
    .b_is_zero      (b_is_zero),
    .m_tlast        (m_tlast)
  );

  // Pack the result fields
  assign m_tdata = {7'd0, result_digit, digit_position};
  assign m_tuser = {b_is_zero, a_is_zero, less, greater, equal, overflow, negative};

endmodule
`default_nettype wire
